// ----- hw/rtl/tsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helpers for the Taylor sine/cosine core.
// No dependencies; every other file of the core imports this package.
package tsc_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int ANGLE_W      = 32;
    localparam int MAG_W        = 32;
    localparam int TERM_W       = 31;
    localparam int X2_W         = 30;
    localparam int SUM_W        = 37;
    localparam int DIFF_W       = SUM_W + 1;
    localparam int PROD_W       = TERM_W + X2_W;
    localparam int NUM_W        = 38;
    localparam int SPLIT_W      = 24;
    localparam int RECIP_W      = 2 * SPLIT_W;
    localparam int RECIP_SHIFT  = 2 * SPLIT_W;
    localparam int PP_W         = 2 * SPLIT_W;
    localparam int TOT_W        = NUM_W + RECIP_W;
    localparam int QUOT_BITS    = 5;
    localparam int RED_LAT      = QUOT_BITS + 5;
    localparam int STEP_LAT     = 4;
    localparam int OUT_LAT      = 3;
    localparam int DEF_SERIES_TERMS = 7;

    // 2*pi with 60 fraction bits, rounded half up to FRAC_BITS
    localparam logic [63:0] TWO_PI_Q60  = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] TWO_PI_FULL = (TWO_PI_Q60 >> (60 - FRAC_BITS))
                                        + ((TWO_PI_Q60 >> (59 - FRAC_BITS)) & 64'd1);
    localparam logic [MAG_W-1:0] TWO_PI = TWO_PI_FULL[MAG_W-1:0];

    localparam logic [TERM_W-1:0] ONE_FIX = TERM_W'(1) << FRAC_BITS;

    localparam logic signed [DIFF_W-1:0] Q_HI = DIFF_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [DIFF_W-1:0] Q_LO = DIFF_W'(-64'sh0000_0000_8000_0000);

    typedef struct packed {
        logic valid;
        logic neg;
    } tsc_ctrl_t;

    function automatic logic [ANGLE_W-1:0] sat_q(input logic signed [DIFF_W-1:0] v);
        logic [ANGLE_W-1:0] r;
        if (v > Q_HI)
            r = Q_HI[ANGLE_W-1:0];
        else if (v < Q_LO)
            r = Q_LO[ANGLE_W-1:0];
        else
            r = v[ANGLE_W-1:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/tsc_reduce.sv -----
`timescale 1ns / 1ps
// Range reduction modulo 2*pi (one quotient bit per stage) and x^2.
// Depends on tsc_pkg.
module tsc_reduce (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [tsc_pkg::ANGLE_W-1:0] angle,
    output tsc_pkg::tsc_ctrl_t          out_ctrl,
    output logic [tsc_pkg::X2_W-1:0]    out_x2,
    output logic [tsc_pkg::TERM_W-1:0]  out_term
);
    import tsc_pkg::*;

    tsc_ctrl_t          ctrl_reg [RED_LAT];
    logic [MAG_W-1:0]   mag0_reg;
    logic [MAG_W-1:0]   mag_reg [QUOT_BITS+1];
    logic [MAG_W-1:0]   rem_reg [QUOT_BITS+1];
    logic               gt_reg  [QUOT_BITS+1];
    logic [TERM_W-1:0]  red_reg;
    logic [TERM_W-1:0]  red_sq_reg;
    logic [TERM_W-1:0]  red_x2_reg;
    logic [2*TERM_W-1:0] sq_reg;
    logic [X2_W-1:0]    x2_reg;
    logic [TERM_W-1:0]  red_next;
    logic [X2_W-1:0]    x2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RED_LAT; i++)
                ctrl_reg[i] <= '0;
        end
        else
        begin
            ctrl_reg[0] <= '{valid: in_valid, neg: angle[ANGLE_W-1]};
            for (int i = 1; i < RED_LAT; i++)
                ctrl_reg[i] <= ctrl_reg[i-1];
        end
    end

    // magnitude, then (m-1) for the modulo path
    always_ff @(posedge clk)
    begin
        mag0_reg   <= angle[ANGLE_W-1] ? (~angle + MAG_W'(1)) : angle;
        mag_reg[0] <= mag0_reg;
        rem_reg[0] <= mag0_reg - MAG_W'(1);
        gt_reg[0]  <= mag0_reg > TWO_PI;
    end

    for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_div
        localparam logic [MAG_W-1:0] STEP_C = TWO_PI << (QUOT_BITS - j);
        always_ff @(posedge clk)
        begin
            rem_reg[j] <= (rem_reg[j-1] >= STEP_C) ? rem_reg[j-1] - STEP_C : rem_reg[j-1];
            mag_reg[j] <= mag_reg[j-1];
            gt_reg[j]  <= gt_reg[j-1];
        end
    end

    assign red_next = gt_reg[QUOT_BITS] ? TERM_W'(rem_reg[QUOT_BITS] + MAG_W'(1))
                                        : TERM_W'(mag_reg[QUOT_BITS]);
    // x^2 rounded half up
    assign x2_next  = X2_W'((sq_reg >> FRAC_BITS) + (2*TERM_W)'(sq_reg[FRAC_BITS-1]));

    always_ff @(posedge clk)
    begin
        red_reg    <= red_next;
        sq_reg     <= (2*TERM_W)'(red_reg) * (2*TERM_W)'(red_reg);
        red_sq_reg <= red_reg;
        x2_reg     <= x2_next;
        red_x2_reg <= red_sq_reg;
    end

    assign out_ctrl = ctrl_reg[RED_LAT-1];
    assign out_x2   = x2_reg;
    assign out_term = red_x2_reg;

endmodule

// ----- hw/rtl/tsc_term_step.sv -----
`timescale 1ns / 1ps
// One series step for sine (lane 0) and cosine (lane 1): accumulate the
// incoming term, then next term = round(term*x^2) / (k*(k-1)). Uses tsc_pkg.
module tsc_term_step #(
    parameter int STEP = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tsc_pkg::tsc_ctrl_t                   in_ctrl,
    input  logic [tsc_pkg::X2_W-1:0]             in_x2,
    input  logic [1:0][tsc_pkg::TERM_W-1:0]      in_term,
    input  logic [1:0][tsc_pkg::SUM_W-1:0]       in_sum,
    output tsc_pkg::tsc_ctrl_t                   out_ctrl,
    output logic [tsc_pkg::X2_W-1:0]             out_x2,
    output logic [1:0][tsc_pkg::TERM_W-1:0]      out_term,
    output logic [1:0][tsc_pkg::SUM_W-1:0]       out_sum
);
    import tsc_pkg::*;

    // incoming term has index STEP-1; odd index terms are subtracted
    localparam bit SUBTRACT = ((STEP - 1) % 2) == 1;

    tsc_ctrl_t       ctrl_reg [STEP_LAT];
    logic [X2_W-1:0] x2_reg   [STEP_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STEP_LAT; i++)
                ctrl_reg[i] <= '0;
        end
        else
        begin
            ctrl_reg[0] <= in_ctrl;
            for (int i = 1; i < STEP_LAT; i++)
                ctrl_reg[i] <= ctrl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        x2_reg[0] <= in_x2;
        for (int i = 1; i < STEP_LAT; i++)
            x2_reg[i] <= x2_reg[i-1];
    end

    for (genvar L = 0; L < 2; L++) begin : g_lane
        localparam longint unsigned K = (L == 0) ? 2 * STEP + 1 : 2 * STEP;
        localparam longint unsigned D = K * (K - 1);
        // ceil(2^48 / d) is exact for every numerator below 2^38
        localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'(((64'd1 << RECIP_SHIFT) + D - 1) / D);
        localparam logic [NUM_W-1:0] HALF_D = NUM_W'(D / 2);

        logic [PROD_W-1:0]       prod_reg;
        logic [NUM_W-1:0]        num_reg;
        logic [PP_W-1:0]         pp_hh_reg, pp_hl_reg, pp_lh_reg, pp_ll_reg;
        logic [TERM_W-1:0]       q_reg;
        logic signed [SUM_W-1:0] sum1_reg, sum2_reg, sum3_reg, sum4_reg;
        logic signed [SUM_W-1:0] term_ext;
        logic [TOT_W-1:0]        total_next;

        assign term_ext = $signed(SUM_W'(in_term[L]));

        assign total_next = (TOT_W'(pp_hh_reg) << (2 * SPLIT_W))
                          + ((TOT_W'(pp_hl_reg) + TOT_W'(pp_lh_reg)) << SPLIT_W)
                          + TOT_W'(pp_ll_reg);

        always_ff @(posedge clk)
        begin
            prod_reg  <= PROD_W'(in_term[L]) * PROD_W'(in_x2);
            sum1_reg  <= SUBTRACT ? $signed(in_sum[L]) - term_ext
                                  : $signed(in_sum[L]) + term_ext;
            num_reg   <= NUM_W'(prod_reg >> FRAC_BITS) + NUM_W'(prod_reg[FRAC_BITS-1])
                       + HALF_D;
            sum2_reg  <= sum1_reg;
            pp_hh_reg <= PP_W'(num_reg[NUM_W-1:SPLIT_W]) * PP_W'(RECIP[RECIP_W-1:SPLIT_W]);
            pp_hl_reg <= PP_W'(num_reg[NUM_W-1:SPLIT_W]) * PP_W'(RECIP[SPLIT_W-1:0]);
            pp_lh_reg <= PP_W'(num_reg[SPLIT_W-1:0]) * PP_W'(RECIP[RECIP_W-1:SPLIT_W]);
            pp_ll_reg <= PP_W'(num_reg[SPLIT_W-1:0]) * PP_W'(RECIP[SPLIT_W-1:0]);
            sum3_reg  <= sum2_reg;
            q_reg     <= total_next[RECIP_SHIFT +: TERM_W];
            sum4_reg  <= sum3_reg;
        end

        assign out_term[L] = q_reg;
        assign out_sum[L]  = sum4_reg;
    end

    assign out_ctrl = ctrl_reg[STEP_LAT-1];
    assign out_x2   = x2_reg[STEP_LAT-1];

endmodule

// ----- hw/rtl/tsc_output.sv -----
`timescale 1ns / 1ps
// Final accumulate, sine sign restore, difference and Q7.24 saturation.
// Depends on tsc_pkg.
module tsc_output #(
    parameter int SERIES_TERMS = tsc_pkg::DEF_SERIES_TERMS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tsc_pkg::tsc_ctrl_t               in_ctrl,
    input  logic [1:0][tsc_pkg::TERM_W-1:0]  in_term,
    input  logic [1:0][tsc_pkg::SUM_W-1:0]   in_sum,
    output logic                             done,
    output logic [tsc_pkg::ANGLE_W-1:0]      sine_value,
    output logic [tsc_pkg::ANGLE_W-1:0]      cosine_value,
    output logic [tsc_pkg::ANGLE_W-1:0]      sine_minus_cosine
);
    import tsc_pkg::*;

    localparam bit SUBTRACT = (SERIES_TERMS % 2) == 1;

    tsc_ctrl_t               ctrl_reg [OUT_LAT];
    logic signed [SUM_W-1:0] sin1_reg, cos1_reg, sin2_reg, cos2_reg;
    logic [ANGLE_W-1:0]      sin_reg, cos_reg, diff_reg;
    logic signed [SUM_W-1:0] sin_t, cos_t;
    logic signed [DIFF_W-1:0] diff_next;

    assign sin_t = $signed(SUM_W'(in_term[0]));
    assign cos_t = $signed(SUM_W'(in_term[1]));
    assign diff_next = DIFF_W'(sin2_reg) - DIFF_W'(cos2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OUT_LAT; i++)
                ctrl_reg[i] <= '0;
        end
        else
        begin
            ctrl_reg[0] <= in_ctrl;
            for (int i = 1; i < OUT_LAT; i++)
                ctrl_reg[i] <= ctrl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sin1_reg <= SUBTRACT ? $signed(in_sum[0]) - sin_t : $signed(in_sum[0]) + sin_t;
        cos1_reg <= SUBTRACT ? $signed(in_sum[1]) - cos_t : $signed(in_sum[1]) + cos_t;
        sin2_reg <= ctrl_reg[0].neg ? -sin1_reg : sin1_reg;
        cos2_reg <= cos1_reg;
        sin_reg  <= sat_q(DIFF_W'(sin2_reg));
        cos_reg  <= sat_q(DIFF_W'(cos2_reg));
        diff_reg <= sat_q(diff_next);
    end

    assign done              = ctrl_reg[OUT_LAT-1].valid;
    assign sine_value        = sin_reg;
    assign cosine_value      = cos_reg;
    assign sine_minus_cosine = diff_reg;

endmodule

// ----- hw/rtl/taylor_sine_cosine_core.sv -----
`timescale 1ns / 1ps
// Taylor sine/cosine core. A start transfer passes the reduction stages, one
// term step per series step (7 by default) and the output stages to done.
// Throughput: one angle per cycle; busy stays low, the pipeline never stalls.
// Reset (rst_n, async, active low) clears every valid bit; data regs do not
// reset. The receiver cannot hold results off: done lasts one cycle.
// Depends on tsc_pkg, tsc_reduce, tsc_term_step and tsc_output.
module taylor_sine_cosine_core #(
    parameter int SERIES_TERMS = tsc_pkg::DEF_SERIES_TERMS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [tsc_pkg::ANGLE_W-1:0] angle,
    output logic                               done,
    output logic signed [tsc_pkg::ANGLE_W-1:0] sine_value,
    output logic signed [tsc_pkg::ANGLE_W-1:0] cosine_value,
    output logic signed [tsc_pkg::ANGLE_W-1:0] sine_minus_cosine
);
    import tsc_pkg::*;

    localparam int LATENCY = RED_LAT + STEP_LAT * SERIES_TERMS + OUT_LAT;

    // Pipeline is always free to take a transfer.
    assign busy = 1'b0;

    // Links between series steps; link 0 is fed by the reduction stages.
    tsc_ctrl_t                   link_ctrl [SERIES_TERMS+1];
    logic [X2_W-1:0]             link_x2   [SERIES_TERMS+1];
    logic [1:0][TERM_W-1:0]      link_term [SERIES_TERMS+1];
    logic [1:0][SUM_W-1:0]       link_sum  [SERIES_TERMS+1];
    logic [TERM_W-1:0]           red_term;
    logic [ANGLE_W-1:0]          sin_raw, cos_raw, diff_raw;

    // Angle magnitude modulo 2*pi, then x^2; the sign rides in the ctrl struct.
    tsc_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .angle    (angle),
        .out_ctrl (link_ctrl[0]),
        .out_x2   (link_x2[0]),
        .out_term (red_term)
    );

    // Sine series starts at x, cosine at 1.0; both running sums start at zero.
    assign link_term[0][0] = red_term;
    assign link_term[0][1] = ONE_FIX;
    assign link_sum[0]     = '0;

    // Each step folds in the previous term and forms the next one.
    for (genvar s = 1; s <= SERIES_TERMS; s++) begin : g_step
        tsc_term_step #(
            .STEP (s)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctrl  (link_ctrl[s-1]),
            .in_x2    (link_x2[s-1]),
            .in_term  (link_term[s-1]),
            .in_sum   (link_sum[s-1]),
            .out_ctrl (link_ctrl[s]),
            .out_x2   (link_x2[s]),
            .out_term (link_term[s]),
            .out_sum  (link_sum[s])
        );
    end

    // Last term, sign of sine, difference, saturation to Q7.24.
    tsc_output #(
        .SERIES_TERMS (SERIES_TERMS)
    ) u_output (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_ctrl           (link_ctrl[SERIES_TERMS]),
        .in_term           (link_term[SERIES_TERMS]),
        .in_sum            (link_sum[SERIES_TERMS]),
        .done              (done),
        .sine_value        (sin_raw),
        .cosine_value      (cos_raw),
        .sine_minus_cosine (diff_raw)
    );

    assign sine_value        = $signed(sin_raw);
    assign cosine_value      = $signed(cos_raw);
    assign sine_minus_cosine = $signed(diff_raw);

    // Every transfer comes out as a done strobe at the end of the pipeline.
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transfer lost in pipeline");

    // No result without an earlier transfer.
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a transfer");

    // Zero angle gives sine 0 and cosine 1.0.
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && angle == '0) |-> ##LATENCY
        (sine_value == '0 && cosine_value == $signed(ANGLE_W'(ONE_FIX))))
        else $error("wrong result for zero angle");

endmodule

// ----- sim/taylor_sine_cosine_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for taylor_sine_cosine_core: directed angles, then random ones.
// Depends on tsc_pkg and the core RTL; a local predictor computes every expected result.
module taylor_sine_cosine_core_tb;

    import tsc_pkg::*;

    localparam int N_TERMS    = DEF_SERIES_TERMS;
    localparam int FRAC       = 24;
    localparam int N_RANDOM   = 1330;
    localparam int DRAIN_CYC  = 13 + 4 * N_TERMS + 20;
    localparam logic [63:0] TWO_PI_Q60_C = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] TERM_CAP     = 64'd1 << 56;

    // one result transfer: sine, cosine, sine minus cosine
    typedef struct packed {
        logic [31:0] sin_v;
        logic [31:0] cos_v;
        logic [31:0] diff_v;
    } trig_t;

    // directed stimulus; has_exp marks rows whose result is typed in
    typedef struct {
        logic [31:0] ang;
        bit          has_exp;
        trig_t       res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] angle = '0;
    logic        busy;
    logic        done;
    logic [31:0] sine_value;
    logic [31:0] cosine_value;
    logic [31:0] sine_minus_cosine;

    trig_t pending_trig[$];
    int    err_count = 0;
    int    sent_count = 0;
    int    got_count = 0;
    bit    stim_done = 1'b0;

    always #4 clk = ~clk;

    taylor_sine_cosine_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .angle             (angle),
        .done              (done),
        .sine_value        (sine_value),
        .cosine_value      (cosine_value),
        .sine_minus_cosine (sine_minus_cosine)
    );

    // ---- predictor arithmetic, 64-bit unsigned with explicit rounding ----

    function automatic logic [63:0] rshift_round(input logic [63:0] v, input int s);
        if (s <= 0)
            return v;
        return (v >> s) + ((v >> (s - 1)) & 64'd1);
    endfunction

    // round(a*b / 2^FRAC), saturated to 2^63-1
    function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        p = p + (128'd1 << (FRAC - 1));
        p = p >> FRAC;
        if (p > 128'h7FFF_FFFF_FFFF_FFFF)
            return 64'h7FFF_FFFF_FFFF_FFFF;
        return p[63:0];
    endfunction

    function automatic logic [63:0] series_term(input logic [63:0] t, input logic [63:0] x2,
                                                input logic [63:0] k);
        logic [63:0] d;
        logic [63:0] p;
        d = k * (k - 64'd1);
        p = fix_mul(t, x2);
        p = (p + d / 2) / d;
        return (p > TERM_CAP) ? TERM_CAP : p;
    endfunction

    // saturate to the Q7.24 range
    function automatic logic [31:0] to_q7_24(input logic signed [63:0] v);
        logic        neg;
        logic [63:0] mag;
        neg = v < 0;
        mag = neg ? 64'd0 - 64'(v) : 64'(v);
        if (!neg)
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        if (mag > 64'h8000_0000)
            mag = 64'h8000_0000;
        return 32'(64'd0 - mag);
    endfunction

    function automatic trig_t predict_trig(input logic [31:0] ang);
        logic               neg;
        logic [63:0]        m;
        logic [63:0]        tp;
        logic [63:0]        x2;
        logic [63:0]        st;
        logic [63:0]        ct;
        logic signed [63:0] ssum;
        logic signed [63:0] csum;
        trig_t              r;
        neg = ang[31];
        m = neg ? (64'd1 << 32) - 64'(ang) : 64'(ang);
        tp = rshift_round(TWO_PI_Q60_C, 60 - FRAC);
        // range reduction: repeated subtraction of 2*pi done as one division
        if (m > tp)
            m = m - ((m - 64'd1) / tp) * tp;
        x2 = fix_mul(m, m);
        st = m;
        ct = 64'd1 << FRAC;
        ssum = st;
        csum = ct;
        for (int i = 1; i <= N_TERMS; i++)
        begin
            st = series_term(st, x2, 64'(2 * i + 1));
            ct = series_term(ct, x2, 64'(2 * i));
            if (i % 2 == 1)
            begin
                ssum = ssum - $signed(st);
                csum = csum - $signed(ct);
            end
            else
            begin
                ssum = ssum + $signed(st);
                csum = csum + $signed(ct);
            end
        end
        if (neg)
            ssum = -ssum;
        r.sin_v = to_q7_24(ssum);
        r.cos_v = to_q7_24(csum);
        r.diff_v = to_q7_24(ssum - csum);
        return r;
    endfunction

    // ---- directed table ----
    stim_row_t dir_rows[$];

    task automatic add_row(input logic [31:0] a);
        stim_row_t s;
        s.ang = a;
        s.has_exp = 1'b0;
        s.res = '{default: '0};
        dir_rows.push_back(s);
    endtask

    task automatic build_dir_rows();
        stim_row_t s;
        // zero angle: sine 0, cosine exactly 1.0
        s.ang = 32'h0;
        s.has_exp = 1'b1;
        s.res = '{32'h0, 32'h0100_0000, 32'hFF00_0000};
        dir_rows.push_back(s);
        add_row(32'h7FFF_FFFF);             // largest positive angle
        add_row(32'h8000_0000);             // most negative angle
        add_row(32'h8000_0001);
        add_row(32'h0000_0001);             // smallest steps around zero
        add_row(32'hFFFF_FFFF);
        add_row(32'h00C9_0FDB);             // about pi/4
        add_row(32'hFF36_F025);             // about -pi/4
        add_row(32'h0192_1FB5);             // about pi/2
        add_row(32'h0324_3F6A);             // about pi
        add_row(32'h0648_7ED5);             // 2*pi exactly: no reduction
        add_row(32'h0648_7ED6);             // just over 2*pi: reduced
        add_row(32'hF9B7_812A);             // just past -2*pi: reduced
        add_row(32'hF9B7_812B);             // -2*pi exactly
        add_row(32'h0648_7ED4);             // just below 2*pi: truncated series near its widest
        add_row(32'h4000_0000);
        add_row(32'h5555_5555);
        add_row(32'hAAAA_AAAA);
        add_row(32'h0100_0000);             // 1.0 and -1.0: sign symmetry
        add_row(32'hFF00_0000);
    endtask

    // ---- stimulus ----

    // drive one angle and hold it until a transfer; gaps at random
    task automatic send_angle(input logic [31:0] a, input bit allow_gaps);
        while (allow_gaps && $urandom_range(99) < 35)
        begin
            start <= 1'b0;
            angle <= $urandom();
            @(posedge clk);
        end
        start <= 1'b1;
        angle <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_trig.push_back(predict_trig(a));
        sent_count++;
    endtask

    function automatic logic [31:0] random_angle();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(32'h0648_7ED5)) *
                          ($urandom_range(1) ? 1 : -1));
            2: return 32'($urandom_range(32'h0324_3F6A)) ^ {32{$urandom_range(1) == 1}};
            3: return {{20{$urandom_range(1) == 1}}, 12'($urandom())};
            4: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                        : 32'h8000_0000 + $urandom_range(255);
            default: return 32'h0648_7ED5 * $urandom_range(1, 20) + $urandom_range(3) - 1;
        endcase
    endfunction

    initial
    begin
        stim_row_t s;
        build_dir_rows();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
        begin
            s = dir_rows[i];
            if (s.has_exp && predict_trig(s.ang) != s.res)
            begin
                $error("predictor disagrees with table row %0d", i);
                err_count++;
            end
            send_angle(s.ang, 1'b1);
        end
        for (int n = 0; n < N_RANDOM; n++)
            send_angle(random_angle(), !(n >= 400 && n < 600));
        start <= 1'b0;
        stim_done = 1'b1;
    end

    // ---- result checking: sampled at the edge that ends the done cycle ----
    always @(posedge clk)
    begin
        trig_t e;
        if (rst_n && done)
        begin
            got_count++;
            if (pending_trig.size() == 0)
            begin
                $error("result transfer with no angle outstanding");
                err_count++;
            end
            else
            begin
                e = pending_trig.pop_front();
                if (sine_value !== e.sin_v)
                begin
                    $error("sine_value expected %h actual %h", e.sin_v, sine_value);
                    err_count++;
                end
                if (cosine_value !== e.cos_v)
                begin
                    $error("cosine_value expected %h actual %h", e.cos_v, cosine_value);
                    err_count++;
                end
                if (sine_minus_cosine !== e.diff_v)
                begin
                    $error("sine_minus_cosine expected %h actual %h",
                           e.diff_v, sine_minus_cosine);
                    err_count++;
                end
            end
        end
    end

    // ---- end of run ----
    initial
    begin
        wait (stim_done);
        while (pending_trig.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        $display("covered %0d angle transfers, %0d results checked", sent_count, got_count);
        $display("directed extremes, 2*pi edges, zero, sign pairs; random wide and reduced");
        if (err_count == 0)
            $display("taylor_sine_cosine_core regression: pass");
        else
            $display("taylor_sine_cosine_core regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("taylor_sine_cosine_core regression: fail");
        $finish;
    end

endmodule
